### src/vdlc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdlc_pkg
// Shared types and constants of the vertical delta line coder.
// ----------------------------------------------------------------------------
package vdlc_pkg;

  // Default line store depth in bytes
  localparam int LINE_MAX_DEF = 4096;

  // Smallest line pitch honoured; smaller values act as this
  localparam int MIN_PITCH = 16;

  // Coded width granule is 16 bytes; this is the round-up mask
  localparam int GRANULE_MASK = 15;

  // APB register map
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_DECODE_MODE = 2'd0,
    REG_ROW_BYTES   = 2'd1,
    REG_LINE_PITCH  = 2'd2,
    REG_FRAME_ROWS  = 2'd3
  } reg_idx_t;

  // Configuration register set
  typedef struct packed {
    logic        decode_mode;
    logic [12:0] row_bytes;
    logic [12:0] line_pitch;
    logic [15:0] frame_rows;
  } cfg_t;

  // Per-word control carried from the scan stage into the store stage
  typedef struct packed {
    logic [7:0] pix;
    logic       code;
    logic       row0;
    logic       eof;
    logic       mode;
  } item_t;

endpackage

### src/vdlc_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdlc_regs
// APB configuration registers: decode mode, row bytes, line pitch, frame rows.
// ----------------------------------------------------------------------------
module vdlc_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [vdlc_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [vdlc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [vdlc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output vdlc_pkg::cfg_t                    cfg
);
  import vdlc_pkg::*;

  reg_idx_t reg_idx;
  logic     wr_en;

  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.decode_mode <= 1'b0;
      cfg.row_bytes   <= 13'd16;
      cfg.line_pitch  <= 13'd16;
      cfg.frame_rows  <= 16'd3;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_DECODE_MODE: cfg.decode_mode <= pwdata[0];
        REG_ROW_BYTES:   cfg.row_bytes   <= pwdata[12:0];
        REG_LINE_PITCH:  cfg.line_pitch  <= pwdata[12:0];
        REG_FRAME_ROWS:  cfg.frame_rows  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_DECODE_MODE: prdata = {{(APB_DATA_W-1){1'b0}}, cfg.decode_mode};
      REG_ROW_BYTES:   prdata = {{(APB_DATA_W-13){1'b0}}, cfg.row_bytes};
      REG_LINE_PITCH:  prdata = {{(APB_DATA_W-13){1'b0}}, cfg.line_pitch};
      REG_FRAME_ROWS:  prdata = {{(APB_DATA_W-16){1'b0}}, cfg.frame_rows};
      default:         prdata = '0;
    endcase
  end

endmodule

### src/vdlc_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdlc_scan
// Raster position counters; classifies each incoming word as coded or padding
// and flags the first row and the end of frame.
// ----------------------------------------------------------------------------
module vdlc_scan #(
  parameter int LineMax = vdlc_pkg::LINE_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  vdlc_pkg::cfg_t             cfg,
  input  logic                       accept,
  input  logic [7:0]                 pixel_in,
  output vdlc_pkg::item_t            item,
  output logic [$clog2(LineMax)-1:0] col
);
  import vdlc_pkg::*;

  localparam int CW   = $clog2(LineMax);
  localparam int CMPW = ((CW > 14) ? CW : 14) + 1;

  logic [CW-1:0]   column_count;
  logic [15:0]     row_count;
  logic [CMPW-1:0] pitch_w;
  logic [CMPW-1:0] rounded_w;
  logic [CMPW-1:0] coded_w;
  logic [CMPW-1:0] col_inc;
  logic [16:0]     rows_w;
  logic [16:0]     row_inc;
  logic            last_col;
  logic            last_row;

  // Effective pitch, coded width and end-of-line / end-of-frame tests
  always_comb begin
    if (CMPW'(cfg.line_pitch) < CMPW'(MIN_PITCH)) begin
      pitch_w = CMPW'(MIN_PITCH);
    end else if (CMPW'(cfg.line_pitch) > CMPW'(LineMax)) begin
      pitch_w = CMPW'(LineMax);
    end else begin
      pitch_w = CMPW'(cfg.line_pitch);
    end
    rounded_w = CMPW'(cfg.row_bytes) + CMPW'(GRANULE_MASK);
    coded_w   = rounded_w & ~CMPW'(GRANULE_MASK);
    if (coded_w > pitch_w) begin
      coded_w = pitch_w;
    end
    col_inc  = CMPW'(column_count) + CMPW'(1);
    last_col = col_inc >= pitch_w;
    rows_w   = (cfg.frame_rows == 16'd0) ? 17'd1 : {1'b0, cfg.frame_rows};
    row_inc  = {1'b0, row_count} + 17'd1;
    last_row = row_inc >= rows_w;
  end

  assign col       = column_count;
  assign item.pix  = pixel_in;
  assign item.code = CMPW'(column_count) < coded_w;
  assign item.row0 = row_count == 16'd0;
  assign item.eof  = last_col && last_row;
  assign item.mode = cfg.decode_mode;

  // Advance the raster position on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? 16'd0 : row_inc[15:0];
      end else begin
        column_count <= col_inc[CW-1:0];
      end
    end
  end

endmodule

### src/vdlc_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdlc_line_store
// Line store memory with read-modify-write datapath and output register.
// Read is issued as a word is accepted; delta and write-back follow from the read register as the word advances.
// ----------------------------------------------------------------------------
module vdlc_line_store #(
  parameter int LineMax = vdlc_pkg::LINE_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  vdlc_pkg::item_t            item,
  input  logic [$clog2(LineMax)-1:0] col,
  input  logic                       out_stall,
  output logic                       ready,
  output logic                       out_valid,
  output logic [7:0]                 pixel_out,
  output logic                       end_of_frame
);
  import vdlc_pkg::*;

  localparam int CW = $clog2(LineMax);

  logic [7:0]    mem [LineMax];
  logic [7:0]    rd_q;
  logic          s1_valid;
  item_t         s1_item;
  logic [CW-1:0] s1_col;
  logic          accept;
  logic          adv;
  logic [7:0]    above;
  logic [7:0]    res;

  assign adv    = s1_valid && (!out_valid || !out_stall);
  assign ready  = !s1_valid || adv;
  assign accept = in_valid && ready;

  // Delta against the byte above; first row predicts from zero
  assign above = s1_item.row0 ? 8'd0 : rd_q;
  assign res   = above - s1_item.pix;

  // Memory: read on accept, write back the predictor as the word leaves.
  // The write and the read in one cycle always hit different columns, as a
  // column comes round again only a full line (at least 16 words) later.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_q <= mem[col];
    end
    if (adv && s1_item.code) begin
      mem[s1_col] <= s1_item.mode ? res : s1_item.pix;
    end
  end

  // Hold the word in flight while its memory read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item;
      s1_col  <= col;
    end
  end

  // Output register; padding columns pass straight through
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pixel_out    <= s1_item.code ? res : s1_item.pix;
      end_of_frame <= s1_item.eof;
    end
  end

endmodule

### src/vertical_delta_line_coder_unit.sv
`timescale 1ns / 1ps
// An accepted word waits in the in-flight register for its store read, then
// moves to the output register, from which the sink takes it.
// Throughput: one word per clock unless the sink stalls, set by the line store's
// single read port (at accept) and single write port (as the word leaves).
// Reset clears the raster counters and loads the register defaults; the line
// store is not cleared, so there is no clearing pass and no wait after reset.
// ----------------------------------------------------------------------------
// vertical_delta_line_coder_unit
// Vertical delta (up prediction) coder/decoder over a byte stream in raster
// order, with an APB configuration port.
// ----------------------------------------------------------------------------
module vertical_delta_line_coder_unit #(
  parameter int LINE_MAX = vdlc_pkg::LINE_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vdlc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [vdlc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [vdlc_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      pixel_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      pixel_out,
  output logic                            end_of_frame
);
  import vdlc_pkg::*;

  localparam int CW = $clog2(LINE_MAX);

  cfg_t          cfg;
  item_t         item;
  logic [CW-1:0] col;
  logic          ready;
  logic          accept;

  assign in_stall = !ready;
  assign accept   = in_valid && ready;

  // Configuration registers
  vdlc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Raster position and word classification
  vdlc_scan #(
    .LineMax (LINE_MAX)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .accept   (accept),
    .pixel_in (pixel_in),
    .item     (item),
    .col      (col)
  );

  // Line store and delta datapath
  vdlc_line_store #(
    .LineMax (LINE_MAX)
  ) u_line_store (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .item         (item),
    .col          (col),
    .out_stall    (out_stall),
    .ready        (ready),
    .out_valid    (out_valid),
    .pixel_out    (pixel_out),
    .end_of_frame (end_of_frame)
  );

endmodule

### dv/vdlc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdlc_checker
// Watches the configuration port and both word channels of the vertical delta
// line coder, predicts each output word from the accepted input words and
// compares every accepted output word with the oldest prediction.
// ----------------------------------------------------------------------------
module vdlc_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [vdlc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [vdlc_pkg::APB_DATA_W-1:0] pwdata,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [7:0]                      pixel_in,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [7:0]                      pixel_out,
  input  logic                            end_of_frame,
  output int unsigned                     fail_count,
  output int unsigned                     words_awaited
);
  import vdlc_pkg::*;

  typedef struct packed {
    logic [7:0] pixel;
    logic       eof;
  } delta_word_t;

  // Own copy of the registers, the line store and the raster position
  cfg_t        regs;
  logic [7:0]  line_mem [LINE_MAX_DEF];
  int unsigned col_pos;
  int unsigned row_pos;
  delta_word_t awaited_q [$];
  int unsigned fails = 0;

  // Code one input word against the byte above and advance the raster
  function automatic delta_word_t code_word(input logic [7:0] pix);
    int unsigned pitch;
    int unsigned coded;
    int unsigned rows;
    logic [7:0]  above;
    delta_word_t w;
    pitch = regs.line_pitch;
    if (pitch < MIN_PITCH) pitch = MIN_PITCH;
    if (pitch > LINE_MAX_DEF) pitch = LINE_MAX_DEF;
    coded = (int'(regs.row_bytes) + GRANULE_MASK) & ~GRANULE_MASK;
    if (coded > pitch) coded = pitch;
    rows = (regs.frame_rows == 16'd0) ? 1 : regs.frame_rows;
    w.pixel = pix;
    // Padding columns pass straight through and leave the store alone
    if (col_pos < coded) begin
      above = (row_pos == 0) ? 8'd0 : line_mem[col_pos];
      w.pixel = above - pix;
      line_mem[col_pos] = regs.decode_mode ? w.pixel : pix;
    end
    w.eof = (col_pos + 1 >= pitch) && (row_pos + 1 >= rows);
    if (col_pos + 1 >= pitch) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= rows) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return w;
  endfunction

  always @(posedge clk) begin : watch
    delta_word_t want;
    if (rst) begin
      regs.decode_mode = 1'b0;
      regs.row_bytes   = 13'd16;
      regs.line_pitch  = 13'd16;
      regs.frame_rows  = 16'd3;
      col_pos = 0;
      row_pos = 0;
      awaited_q.delete();
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[APB_ADDR_W-1:2]))
          REG_DECODE_MODE: regs.decode_mode = pwdata[0];
          REG_ROW_BYTES:   regs.row_bytes   = pwdata[12:0];
          REG_LINE_PITCH:  regs.line_pitch  = pwdata[12:0];
          REG_FRAME_ROWS:  regs.frame_rows  = pwdata[15:0];
          default: ;
        endcase
      end
      // Compare the output word with the oldest prediction
      if (out_valid && !out_stall) begin
        if (awaited_q.size() == 0) begin
          $error("unexpected output word: pixel_out %0h end_of_frame %0b",
                 pixel_out, end_of_frame);
          fails++;
        end else begin
          want = awaited_q.pop_front();
          if (pixel_out !== want.pixel) begin
            $error("pixel_out mismatch: expected %0h, actual %0h", want.pixel, pixel_out);
            fails++;
          end
          if (end_of_frame !== want.eof) begin
            $error("end_of_frame mismatch: expected %0b, actual %0b",
                   want.eof, end_of_frame);
            fails++;
          end
        end
      end
      // Predict each accepted input word
      if (in_valid && !in_stall) awaited_q.push_back(code_word(pixel_in));
    end
    fail_count    <= fails;
    words_awaited <= awaited_q.size();
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the vertical delta line coder: a short directed frame, then
// phases of random words under a sweep of register settings, with random
// gaps and stalls on both channels; the checker beside the block does the
// prediction and comparison.
// ----------------------------------------------------------------------------
module tb;
  import vdlc_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_SLACK  = 4;
  localparam int unsigned RANDOM_WORDS = 500;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            pixel_in;
  logic                  out_valid;
  logic                  out_stall;
  logic [7:0]            pixel_out;
  logic                  end_of_frame;
  int unsigned           fail_count;
  int unsigned           words_awaited;

  // Stimulus bookkeeping: register values written and raster position
  cfg_t        shadow;
  int unsigned raster_col;
  int unsigned raster_row;
  bit          src_dense;
  bit          sink_hold_req;
  int unsigned quiet_cycles;

  always #4 clk = ~clk;

  vertical_delta_line_coder_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pixel_in     (pixel_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_out    (pixel_out),
    .end_of_frame (end_of_frame)
  );

  vdlc_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .pixel_in      (pixel_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_out     (pixel_out),
    .end_of_frame  (end_of_frame),
    .fail_count    (fail_count),
    .words_awaited (words_awaited)
  );

  function automatic int unsigned pitch_in_use(input logic [12:0] pitch);
    if (pitch < MIN_PITCH) return MIN_PITCH;
    if (pitch > LINE_MAX_DEF) return LINE_MAX_DEF;
    return pitch;
  endfunction

  // Random byte, leaning towards the extremes
  function automatic logic [7:0] any_byte();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Advance the raster position by one accepted word
  function automatic void step_raster();
    int unsigned p;
    int unsigned rows;
    p = pitch_in_use(shadow.line_pitch);
    rows = (shadow.frame_rows == 16'd0) ? 1 : shadow.frame_rows;
    if (raster_col + 1 >= p) begin
      raster_col = 0;
      raster_row = (raster_row + 1 >= rows) ? 0 : raster_row + 1;
    end else begin
      raster_col = raster_col + 1;
    end
  endfunction

  // Register write: setup cycle, then access cycle until pready
  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DECODE_MODE: shadow.decode_mode = val[0];
      REG_ROW_BYTES:   shadow.row_bytes   = val[12:0];
      REG_LINE_PITCH:  shadow.line_pitch  = val[12:0];
      REG_FRAME_ROWS:  shadow.frame_rows  = val[15:0];
      default: ;
    endcase
  endtask

  // Offer one word, hold it until accepted, then maybe idle a while
  task automatic send_word(input logic [7:0] b);
    int r;
    in_valid <= 1'b1;
    pixel_in <= b;
    do @(posedge clk); while (in_stall);
    step_raster();
    if (!src_dense) begin
      r = $urandom_range(0, 99);
      if (r >= 55) begin
        in_valid <= 1'b0;
        repeat (r < 90 ? $urandom_range(1, 3) : $urandom_range(8, 30)) @(posedge clk);
      end
    end
  endtask

  // Drop valid and wait until every predicted word has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_awaited != 0);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // Finish the current row as a one-row frame so the next setting starts
  // at a frame boundary; the pitch shrink ends a long row at once
  task automatic realign();
    if (raster_col != 0 || raster_row != 0) begin
      reg_write(REG_FRAME_ROWS, 32'd1);
      reg_write(REG_LINE_PITCH, 32'd16);
      while (raster_col != 0 || raster_row != 0) send_word(any_byte());
      wait_drained();
    end
  endtask

  // Sink pacing: random stall spans, plus one long hold-off on request
  initial begin : sink_pacing
    int   mode;
    int   span;
    logic level;
    bit   held;
    out_stall = 1'b0;
    held      = 1'b0;
    @(posedge clk);
    forever begin
      if (sink_hold_req && !held) begin
        held  = 1'b1;
        level = 1'b1;
        span  = HOLD_CYCLES;
      end else begin
        mode = $urandom_range(0, 99);
        if (mode < 45) begin
          level = 1'b0;
          span  = $urandom_range(1, 40);
        end else if (mode < 90) begin
          level = 1'b1;
          span  = $urandom_range(1, 3);
        end else begin
          level = 1'b1;
          span  = $urandom_range(8, 40);
        end
      end
      out_stall <= level;
      repeat (span) @(posedge clk);
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $error("no word moved for %0d cycles", QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [7:0]  corner [8];
    int unsigned sent_random;
    int unsigned phase_no;
    int unsigned words;
    int unsigned total;
    int unsigned ep;
    int unsigned er;
    int          r;
    logic [31:0] mv;
    logic [31:0] rbv;
    logic [31:0] pv;
    logic [31:0] rwv;
    bit          pause_mid;

    corner = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA};
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_valid = 1'b0;
    pixel_in = 8'h00;
    shadow   = '{decode_mode: 1'b0, row_bytes: 13'd16, line_pitch: 13'd16,
                 frame_rows: 16'd3};
    raster_col    = 0;
    raster_row    = 0;
    src_dense     = 1'b0;
    sink_hold_req = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frame: one row rounded up to 16, row zero predicts from zero,
    // extreme bytes, encode on the first row and decode on the second
    reg_write(REG_DECODE_MODE, 32'd0);
    reg_write(REG_ROW_BYTES, 32'd1);
    reg_write(REG_LINE_PITCH, 32'd16);
    reg_write(REG_FRAME_ROWS, 32'd2);
    for (int i = 0; i < 16; i++) send_word(i < 8 ? corner[i] : any_byte());
    wait_drained();
    reg_write(REG_DECODE_MODE, 32'd1);
    for (int i = 0; i < 16; i++) send_word(i < 8 ? corner[7 - i] : any_byte());

    // Phases of random words under a sweep of settings, extremes first
    sent_random = 0;
    phase_no    = 0;
    while (sent_random < RANDOM_WORDS) begin
      src_dense = 1'b0;
      pause_mid = 1'b0;
      case (phase_no)
        0: begin
          // widest line, pitch above the store clamps to it; left early in the row
          mv = 0; rbv = 4096; pv = 8191; rwv = 2; words = 48;
          src_dense = 1'b1;
        end
        1: begin
          // sink holds off while the source keeps offering
          mv = 1; rbv = 32; pv = 32; rwv = 3; words = 96;
          src_dense = 1'b1;
        end
        2: begin
          // nothing coded, tiny pitch, zero rows acting as one
          mv = 0; rbv = 0; pv = 0; rwv = 0; words = 48;
        end
        3: begin
          // coded width past a pitch that is not a multiple of 16, one-row frames
          mv = 1; rbv = 8191; pv = 20; rwv = 1; words = 60;
        end
        4: begin
          // tallest frame, left mid-row past the shrunken pitch
          mv = 0; rbv = 17; pv = 37; rwv = 65535; words = 37 * 3 + 21;
        end
        5: begin
          // two-row frames with a pause until everything is out
          mv = 1; rbv = 1; pv = 16; rwv = 2; words = 64;
          pause_mid = 1'b1;
        end
        default: begin
          mv = $urandom_range(0, 1);
          r = $urandom_range(0, 99);
          if (r < 10) pv = $urandom_range(0, 15);
          else if (r < 60) pv = 16 * $urandom_range(1, 2);
          else pv = $urandom_range(16, 50);
          r = $urandom_range(0, 99);
          if (r < 10) rbv = 0;
          else if (r < 20) rbv = $urandom_range(4096, 8191);
          else rbv = $urandom_range(1, pv + 8);
          rwv = $urandom_range(0, 4);
          ep = pitch_in_use(pv[12:0]);
          er = (rwv == 0) ? 1 : rwv;
          total = ep * er;
          words = ($urandom_range(0, 3) == 0) ? $urandom_range(1, total) : total;
          src_dense = ($urandom_range(0, 3) == 0);
          pause_mid = ($urandom_range(0, 3) == 0);
        end
      endcase

      wait_drained();
      realign();
      reg_write(REG_DECODE_MODE, mv);
      reg_write(REG_ROW_BYTES, rbv);
      reg_write(REG_LINE_PITCH, pv);
      reg_write(REG_FRAME_ROWS, rwv);
      if (phase_no == 1) sink_hold_req = 1'b1;

      for (int unsigned i = 0; i < words; i++) begin
        if (pause_mid && i == words / 2) wait_drained();
        send_word(any_byte());
      end
      sent_random += words;
      phase_no++;
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### vertical_delta_line_coder_unit.f
src/vdlc_pkg.sv
src/vdlc_regs.sv
src/vdlc_scan.sv
src/vdlc_line_store.sv
src/vertical_delta_line_coder_unit.sv
dv/vdlc_checker.sv
dv/tb.sv
